// ----- design/lmsd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmsd_pkg
// Shared types, widths and helpers for the LED matrix scan unit.
// ----------------------------------------------------------------------------
package lmsd_pkg;

  localparam int unsigned RowIdxW  = 3;
  localparam int unsigned PatW     = 8;
  localparam int unsigned CntW     = 4;
  localparam int unsigned EntryW   = PatW + CntW;
  localparam int unsigned Rows     = 8;
  localparam int unsigned Entries  = 2 * Rows;
  localparam int unsigned AddrW    = $clog2(Entries);
  localparam int unsigned ScanW    = 5;
  localparam int unsigned LowColW  = 6;
  localparam int unsigned HighColW = 2;
  localparam int unsigned ThrW     = 4;
  localparam int unsigned ThrReset = 4;
  localparam int unsigned LastRow  = 7;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SWAP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_DIM_THRESHOLD = 1'b0
  } reg_idx_t;

  // number of lit LEDs in a row pattern
  function automatic logic [CntW-1:0] lit_count(input logic [PatW-1:0] v);
    logic [CntW-1:0] n;
    n = '0;
    for (int i = 0; i < PatW; i++) begin
      n = n + CntW'(v[i]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- design/led_matrix_scan_double_buffer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_scan_double_buffer_unit
// 8x8 LED matrix column scanner with a double-buffered frame store and
// threshold-based blanking in the dim half of each scan pass.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  in_*     | slave     | tuser: op[1:0]; tdata: row_index[2:0], row_bits[10:3]
//  out_*    | master    | tdata: col_low_select, col_high_select, led_drive;
//           |           | tuser: blanked
//  cfg_*    | APB slave | 0x0: dim_threshold[3:0]
//
// One item per cycle unless stalled. A scan tick yields its transfer on out_*
// in the cycle after acceptance, from the output register; writes and swap
// requests produce no transfer. in_tready drops only while the output register
// holds an untaken transfer and out_tready is low. rst_n (synchronous) clears
// the frame store, scan counter, buffer select, swap and lock flags.
// ----------------------------------------------------------------------------
module led_matrix_scan_double_buffer_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // slave stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [lmsd_pkg::InDataW-1:0]       in_tdata,   // row_index, row_bits, pad
  input  wire logic [1:0]                         in_tuser,   // op
  // master stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [lmsd_pkg::OutDataW-1:0]           out_tdata,  // col_low, col_high, led_drive
  output logic                                    out_tuser,  // blanked
  // configuration
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [lmsd_pkg::CfgAddrW-1:0]      cfg_paddr,
  input  wire logic [lmsd_pkg::CfgDataW-1:0]      cfg_pwdata,
  output logic [lmsd_pkg::CfgDataW-1:0]           cfg_prdata,
  output logic                                    cfg_pready
);

  logic [lmsd_pkg::EntryW-1:0]    store_r [lmsd_pkg::Entries];
  logic [lmsd_pkg::ScanW-1:0]     scan_r;
  logic                           front_r;
  logic                           swap_r;
  logic                           lock_r;
  logic [lmsd_pkg::ThrW-1:0]      thr_r;

  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic [lmsd_pkg::OutDataW-1:0]  out_data_r;
  logic                           out_blank_r;

  lmsd_pkg::op_t                  op;
  logic [lmsd_pkg::RowIdxW-1:0]   row_idx;
  logic [lmsd_pkg::PatW-1:0]      row_bits;
  logic                           accept;
  logic                           cfg_wr;
  logic                           cfg_hit;

  logic [lmsd_pkg::AddrW-1:0]     wr_addr;
  logic [lmsd_pkg::AddrW-1:0]     rd_addr;
  logic [lmsd_pkg::RowIdxW-1:0]   col;
  logic [lmsd_pkg::EntryW-1:0]    entry;
  logic [lmsd_pkg::PatW-1:0]      pattern;
  logic [lmsd_pkg::CntW-1:0]      count;
  logic                           blank;
  logic [lmsd_pkg::PatW-1:0]      col_onehot;
  logic [lmsd_pkg::OutDataW-1:0]  tick_data;
  logic [lmsd_pkg::ScanW-1:0]     scan_nxt;
  logic                           wrap;

  assign op       = lmsd_pkg::op_t'(in_tuser);
  assign row_idx  = in_tdata[lmsd_pkg::RowIdxW-1:0];
  assign row_bits = in_tdata[lmsd_pkg::RowIdxW +: lmsd_pkg::PatW];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // a new tick loads the output register; otherwise a taken transfer empties it
  assign out_valid_nxt = (accept && op == lmsd_pkg::OP_TICK) ? 1'b1
                       : (out_tready ? 1'b0 : out_valid_r);

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[lmsd_pkg::CfgAddrW-1] == 1'(lmsd_pkg::REG_DIM_THRESHOLD));
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? lmsd_pkg::CfgDataW'(thr_r) : '0;

  assign wr_addr = {~front_r, row_idx};
  assign col     = scan_r[lmsd_pkg::RowIdxW-1:0];
  assign rd_addr = {front_r, col};
  assign entry   = store_r[rd_addr];
  assign pattern = entry[lmsd_pkg::PatW-1:0];
  assign count   = entry[lmsd_pkg::PatW +: lmsd_pkg::CntW];
  // dim phase is bit 3 of the scan counter; bit 4 only extends the pass
  assign blank   = scan_r[lmsd_pkg::RowIdxW] && (count < thr_r);

  assign col_onehot = lmsd_pkg::PatW'(1) << col;
  assign tick_data  = blank ? '0 : {pattern, col_onehot};

  assign scan_nxt = scan_r + lmsd_pkg::ScanW'(1);
  assign wrap     = (scan_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lmsd_pkg::Entries; i++) begin
        store_r[i] <= '0;
      end
      scan_r      <= '0;
      front_r     <= 1'b0;
      swap_r      <= 1'b0;
      lock_r      <= 1'b0;
      thr_r       <= lmsd_pkg::ThrW'(lmsd_pkg::ThrReset);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        thr_r <= cfg_pwdata[lmsd_pkg::ThrW-1:0];
      end
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        unique case (op)
          lmsd_pkg::OP_WRITE: begin
            store_r[wr_addr] <= {lmsd_pkg::lit_count(row_bits), row_bits};
            lock_r <= (row_idx != lmsd_pkg::RowIdxW'(lmsd_pkg::LastRow));
          end
          lmsd_pkg::OP_SWAP: begin
            swap_r <= 1'b1;
          end
          lmsd_pkg::OP_TICK: begin
            scan_r      <= scan_nxt;
            if (wrap && swap_r && !lock_r) begin
              front_r <= ~front_r;
              swap_r  <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    if (accept && op == lmsd_pkg::OP_TICK) begin
      out_data_r  <= tick_data;
      out_blank_r <= blank;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_blank_r;

  // a blanked transfer carries no column select and no pattern
  a_blank_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_blank_r) |-> (out_data_r == '0))
    else $error("blanked transfer with nonzero data");

  // an unblanked transfer selects exactly one column
  a_col_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_blank_r) |-> $onehot(out_data_r[lmsd_pkg::PatW-1:0]))
    else $error("column select not one-hot");

  // the shown buffer changes only through an armed swap
  a_swap_armed: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(front_r)) |-> ($past(swap_r) && !$past(lock_r)))
    else $error("buffer swap without an armed request");

  // a scan transfer appears only after an accepted tick
  a_tick_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept && op == lmsd_pkg::OP_TICK))
    else $error("result without a tick");

endmodule
`default_nettype wire
